FILE: rtl/acir_pkg.sv
package acir_pkg;

    // Fixed field widths
    localparam int FRAME_W     = 28;
    localparam int DUR_OUT_W   = 16;
    localparam int TENTHS_W    = 10;
    localparam int DEG_W       = 5;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;

    // Frame fields
    localparam logic [FRAME_W-1:0] SIGNATURE       = 28'h8800000;
    localparam logic [FRAME_W-1:0] CMD_MODE_CHANGE = 28'h0008000;
    localparam logic [FRAME_W-1:0] CMD_OFF         = 28'h00C0000;
    localparam logic [FRAME_W-1:0] CMD_SWING       = 28'h0010000;
    localparam logic [FRAME_W-1:0] CMD_HEAT_COOL   = 28'h000B000;
    localparam logic [FRAME_W-1:0] CMD_DRY         = 28'h0009000;
    localparam logic [FRAME_W-1:0] CMD_HEAT        = 28'h0004000;
    localparam logic [FRAME_W-1:0] CMD_FAN_ONLY    = 28'h0002000;

    localparam logic [7:0] FAN_NIB_AUTO = 8'h50;
    localparam logic [7:0] FAN_NIB_MED  = 8'h20;
    localparam logic [7:0] FAN_NIB_HIGH = 8'h40;

    // Mode codes
    localparam logic [2:0] MODE_OFF       = 3'd0;
    localparam logic [2:0] MODE_COOL      = 3'd1;
    localparam logic [2:0] MODE_HEAT      = 3'd2;
    localparam logic [2:0] MODE_HEAT_COOL = 3'd3;
    localparam logic [2:0] MODE_DRY       = 3'd4;
    localparam logic [2:0] MODE_FAN_ONLY  = 3'd5;

    // Fan codes
    localparam logic [1:0] FAN_SPD_AUTO = 2'd0;
    localparam logic [1:0] FAN_LOW      = 2'd1;
    localparam logic [1:0] FAN_MED      = 2'd2;
    localparam logic [1:0] FAN_HIGH     = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_HEADER_MARK  = 3'd0;
    localparam logic [2:0] REG_HEADER_SPACE = 3'd1;
    localparam logic [2:0] REG_BIT_MARK     = 3'd2;
    localparam logic [2:0] REG_ONE_SPACE    = 3'd3;
    localparam logic [2:0] REG_ZERO_SPACE   = 3'd4;
    localparam logic [2:0] REG_TEMP_MIN     = 3'd5;
    localparam logic [2:0] REG_TEMP_MAX     = 3'd6;

    // Register reset values
    localparam logic [DUR_OUT_W-1:0] HDR_MARK_RST   = 16'd8000;
    localparam logic [DUR_OUT_W-1:0] HDR_SPACE_RST  = 16'd4000;
    localparam logic [DUR_OUT_W-1:0] BIT_MARK_RST   = 16'd600;
    localparam logic [DUR_OUT_W-1:0] ONE_SPACE_RST  = 16'd1600;
    localparam logic [DUR_OUT_W-1:0] ZERO_SPACE_RST = 16'd550;
    localparam logic [DEG_W-1:0]     TEMP_MIN_RST   = 5'd18;
    localparam logic [DEG_W-1:0]     TEMP_MAX_RST   = 5'd30;

    // Temperature nibble
    localparam logic [DEG_W-1:0] DEG_MIN      = 5'd15;
    localparam logic [DEG_W-1:0] DEG_MAX      = 5'd30;
    localparam logic [3:0]       FAN_ONLY_NIB = 4'd3;   // 18 degrees
    localparam logic [7:0]       RECIP_10     = 8'd205; // x/10 == (x*205)>>11 for x < 1029
    localparam int               RECIP_SHIFT  = 11;

    // Captured command, clamp already applied
    typedef struct packed {
        logic       swing;
        logic [2:0] mode;
        logic [1:0] fan;
        logic [8:0] tenths_rnd;   // clamped tenths + 5
    } cmd_t;

endpackage

FILE: rtl/acir_cmd_if.sv
interface acir_cmd_if
    import acir_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                swing_toggle;
    logic [2:0]          mode_code;
    logic [1:0]          fan_code;
    logic [TENTHS_W-1:0] target_tenths;

    modport source (
        output valid, swing_toggle, mode_code, fan_code, target_tenths,
        input  ready
    );

    modport sink (
        input  valid, swing_toggle, mode_code, fan_code, target_tenths,
        output ready
    );
endinterface

FILE: rtl/acir_pulse_if.sv
interface acir_pulse_if
    import acir_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [DUR_OUT_W-1:0] mark_duration;
    logic [DUR_OUT_W-1:0] space_duration;
    logic                 is_last;
    logic [FRAME_W-1:0]   frame_word;

    modport source (
        output valid, mark_duration, space_duration, is_last, frame_word,
        input  ready
    );

    modport sink (
        input  valid, mark_duration, space_duration, is_last, frame_word,
        output ready
    );
endinterface

FILE: rtl/ac_ir_frame_encoder.sv
// Air-conditioner IR frame encoder, 28-bit pulse-distance format.
// cmd   : one item per command (swing, mode, fan, target in tenths of a degree).
// pulse : FRAME_BITS+2 items per command: header mark/space, one mark/space per
//         data bit (MSB first), then the trailer mark with is_last set and a
//         zero space. frame_word carries the finished frame on every item.
// APB   : seven timing/temperature registers at byte address 4*index, pready tied
//         high. The user must write only while idle; the block does not check.
// Timing: cmd.ready is high only while idle. After acceptance the build state
//         builds the frame, the sum state adds up the checksum a nibble at a
//         time, then the emit state shifts out one pulse per cycle from the
//         bit-serial shift register while the receiver does not stall.
// Stall : the output register holds the pulse until taken; the shift register
//         waits with it. The next command can be taken while the trailer waits.
// Reset : registers return to their defaults, the stored previous mode to off,
//         and the output is empty.
module ac_ir_frame_encoder
    import acir_pkg::*;
#(
    parameter int FRAME_BITS     = 28,
    parameter int DURATION_WIDTH = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    acir_cmd_if.sink              cmd,
    acir_pulse_if.source          pulse,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Durations keep only the bits both the parameter and the port allow
    localparam int DUR_KEEP    = (DURATION_WIDTH < DUR_OUT_W) ? DURATION_WIDTH : DUR_OUT_W;
    localparam int CNT_W       = $clog2(FRAME_BITS + 2);
    localparam logic [CNT_W-1:0] LAST_PULSE = CNT_W'(FRAME_BITS + 1);
    localparam int SUM_NIBBLES = (FRAME_W - 4) / 4;
    localparam int SUM_CNT_W   = $clog2(SUM_NIBBLES);
    localparam int NIB_SH_W    = FRAME_W - 4;

    typedef enum logic [1:0] {ST_IDLE, ST_BUILD, ST_SUM, ST_EMIT} state_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [DUR_KEEP-1:0] hdr_mark_reg, hdr_space_reg, bit_mark_reg;
    logic [DUR_KEEP-1:0] one_space_reg, zero_space_reg;
    logic [DEG_W-1:0]    temp_min_reg, temp_max_reg;
    logic [2:0]          reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_mark_reg   <= DUR_KEEP'(HDR_MARK_RST);
            hdr_space_reg  <= DUR_KEEP'(HDR_SPACE_RST);
            bit_mark_reg   <= DUR_KEEP'(BIT_MARK_RST);
            one_space_reg  <= DUR_KEEP'(ONE_SPACE_RST);
            zero_space_reg <= DUR_KEEP'(ZERO_SPACE_RST);
            temp_min_reg   <= TEMP_MIN_RST;
            temp_max_reg   <= TEMP_MAX_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_HEADER_MARK:  hdr_mark_reg   <= pwdata[DUR_KEEP-1:0];
                REG_HEADER_SPACE: hdr_space_reg  <= pwdata[DUR_KEEP-1:0];
                REG_BIT_MARK:     bit_mark_reg   <= pwdata[DUR_KEEP-1:0];
                REG_ONE_SPACE:    one_space_reg  <= pwdata[DUR_KEEP-1:0];
                REG_ZERO_SPACE:   zero_space_reg <= pwdata[DUR_KEEP-1:0];
                REG_TEMP_MIN:     temp_min_reg   <= pwdata[DEG_W-1:0];
                REG_TEMP_MAX:     temp_max_reg   <= pwdata[DEG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_HEADER_MARK:  prdata = APB_DATA_W'(hdr_mark_reg);
            REG_HEADER_SPACE: prdata = APB_DATA_W'(hdr_space_reg);
            REG_BIT_MARK:     prdata = APB_DATA_W'(bit_mark_reg);
            REG_ONE_SPACE:    prdata = APB_DATA_W'(one_space_reg);
            REG_ZERO_SPACE:   prdata = APB_DATA_W'(zero_space_reg);
            REG_TEMP_MIN:     prdata = APB_DATA_W'(temp_min_reg);
            REG_TEMP_MAX:     prdata = APB_DATA_W'(temp_max_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Command capture: unused modes fold to off, target clamped
    // (lower bound first, so the upper bound wins when they cross)
    // ---------------------------------------------------------------
    logic [8:0]          lo_tenths, hi_tenths;
    logic [TENTHS_W-1:0] t_lo;
    logic [8:0]          t_clamp;
    cmd_t                cmd_next;

    always_comb
    begin
        lo_tenths = (9'(temp_min_reg) << 3) + (9'(temp_min_reg) << 1);
        hi_tenths = (9'(temp_max_reg) << 3) + (9'(temp_max_reg) << 1);
        t_lo = (cmd.target_tenths < TENTHS_W'(lo_tenths)) ? TENTHS_W'(lo_tenths)
                                                          : cmd.target_tenths;
        t_clamp = (t_lo > TENTHS_W'(hi_tenths)) ? hi_tenths : t_lo[8:0];

        cmd_next.swing      = cmd.swing_toggle;
        cmd_next.mode       = (cmd.mode_code > MODE_FAN_ONLY) ? MODE_OFF : cmd.mode_code;
        cmd_next.fan        = cmd.fan_code;
        cmd_next.tenths_rnd = t_clamp + 9'd5;
    end

    // ---------------------------------------------------------------
    // Frame build (checksum nibble left at zero)
    // ---------------------------------------------------------------
    state_t               state_reg;
    cmd_t                 cmd_reg;
    logic [2:0]           prev_mode_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [FRAME_W-1:0]   frame_next;
    logic [15:0]          deg_prod;
    logic [DEG_W-1:0]     deg_raw, deg_sat;
    logic [3:0]           temp_nib;

    always_comb
    begin
        deg_prod = 16'(cmd_reg.tenths_rnd) * 16'(RECIP_10);
        deg_raw  = deg_prod[RECIP_SHIFT +: DEG_W];
        if (deg_raw < DEG_MIN)
            deg_sat = DEG_MIN;
        else if (deg_raw > DEG_MAX)
            deg_sat = DEG_MAX;
        else
            deg_sat = deg_raw;
        temp_nib = 4'(deg_sat - DEG_MIN);

        frame_next = SIGNATURE;
        if (cmd_reg.swing)
        begin
            frame_next = frame_next | CMD_SWING;
        end
        else
        begin
            unique case (cmd_reg.mode)
                MODE_COOL:      ;
                MODE_HEAT:      frame_next = frame_next | CMD_HEAT;
                MODE_HEAT_COOL: frame_next = frame_next | CMD_HEAT_COOL;
                MODE_DRY:       frame_next = frame_next | CMD_DRY;
                MODE_FAN_ONLY:  frame_next = frame_next | CMD_FAN_ONLY;
                default:        frame_next = frame_next | CMD_OFF;
            endcase

            // mode change unless switching on from off or switching off
            if (cmd_reg.mode != MODE_OFF && prev_mode_reg != MODE_OFF)
                frame_next = frame_next | CMD_MODE_CHANGE;

            case (cmd_reg.mode) inside
                MODE_OFF:
                    frame_next = frame_next | FRAME_W'(FAN_NIB_AUTO);
                MODE_HEAT_COOL:
                    ;
                default:
                begin
                    case (cmd_reg.fan)
                        FAN_HIGH: frame_next = frame_next | FRAME_W'(FAN_NIB_HIGH);
                        FAN_MED:  frame_next = frame_next | FRAME_W'(FAN_NIB_MED);
                        FAN_LOW:  ;
                        default:  frame_next = frame_next | FRAME_W'(FAN_NIB_AUTO);
                    endcase
                end
            endcase

            case (cmd_reg.mode) inside
                MODE_COOL, MODE_HEAT, MODE_DRY:
                    frame_next = frame_next | FRAME_W'({temp_nib, 8'h00});
                MODE_FAN_ONLY:
                    frame_next = frame_next | FRAME_W'({FAN_ONLY_NIB, 8'h00});
                default:
                    ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Checksum, a nibble per cycle, and bit-serial emission
    // ---------------------------------------------------------------
    logic [NIB_SH_W-1:0]  nib_sh_reg;
    logic [SUM_CNT_W-1:0] sum_cnt_reg;
    logic [3:0]           sum_reg;
    logic [3:0]           sum_next;
    logic [FRAME_W-1:0]   frame_done;
    logic [FRAME_BITS-1:0] bit_sh_reg;
    logic [CNT_W-1:0]     pulse_cnt_reg;

    logic                 out_valid_reg;
    logic [DUR_OUT_W-1:0] out_mark_reg, out_space_reg;
    logic                 out_last_reg;
    logic [FRAME_W-1:0]   out_frame_reg;
    logic                 out_load;

    assign sum_next   = sum_reg + nib_sh_reg[3:0];
    assign frame_done = {frame_reg[FRAME_W-1:4], sum_next};
    assign out_load   = !out_valid_reg || pulse.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            prev_mode_reg <= MODE_OFF;
            frame_reg     <= '0;
            nib_sh_reg    <= '0;
            sum_cnt_reg   <= '0;
            sum_reg       <= '0;
            bit_sh_reg    <= '0;
            pulse_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            out_mark_reg  <= '0;
            out_space_reg <= '0;
            out_last_reg  <= 1'b0;
            out_frame_reg <= '0;
        end
        else
        begin
            // output register refills while emitting, else empties once taken
            if (out_load)
                out_valid_reg <= (state_reg == ST_EMIT);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        cmd_reg   <= cmd_next;
                        state_reg <= ST_BUILD;
                    end
                end

                ST_BUILD:
                begin
                    frame_reg   <= frame_next;
                    nib_sh_reg  <= frame_next[FRAME_W-1:4];
                    sum_reg     <= '0;
                    sum_cnt_reg <= SUM_CNT_W'(SUM_NIBBLES - 1);
                    if (!cmd_reg.swing)
                        prev_mode_reg <= cmd_reg.mode;
                    state_reg   <= ST_SUM;
                end

                ST_SUM:
                begin
                    sum_reg     <= sum_next;
                    nib_sh_reg  <= nib_sh_reg >> 4;
                    sum_cnt_reg <= sum_cnt_reg - SUM_CNT_W'(1);
                    if (sum_cnt_reg == '0)
                    begin
                        frame_reg     <= frame_done;
                        bit_sh_reg    <= FRAME_BITS'(frame_done);
                        pulse_cnt_reg <= '0;
                        state_reg     <= ST_EMIT;
                    end
                end

                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        out_frame_reg <= frame_reg;
                        pulse_cnt_reg <= pulse_cnt_reg + CNT_W'(1);
                        if (pulse_cnt_reg == '0)
                        begin
                            // header
                            out_mark_reg  <= DUR_OUT_W'(hdr_mark_reg);
                            out_space_reg <= DUR_OUT_W'(hdr_space_reg);
                            out_last_reg  <= 1'b0;
                        end
                        else if (pulse_cnt_reg == LAST_PULSE)
                        begin
                            // trailer mark
                            out_mark_reg  <= DUR_OUT_W'(bit_mark_reg);
                            out_space_reg <= '0;
                            out_last_reg  <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            out_mark_reg  <= DUR_OUT_W'(bit_mark_reg);
                            out_space_reg <= bit_sh_reg[FRAME_BITS-1]
                                             ? DUR_OUT_W'(one_space_reg)
                                             : DUR_OUT_W'(zero_space_reg);
                            out_last_reg  <= 1'b0;
                            bit_sh_reg    <= bit_sh_reg << 1;
                        end
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cmd.ready            = (state_reg == ST_IDLE);
    assign pulse.valid          = out_valid_reg;
    assign pulse.mark_duration  = out_mark_reg;
    assign pulse.space_duration = out_space_reg;
    assign pulse.is_last        = out_last_reg;
    assign pulse.frame_word     = out_frame_reg;

endmodule

FILE: rtl/acir_checker.sv
module acir_checker
    import acir_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input logic                 cmd_ready,
    input logic                 pulse_valid,
    input logic                 pulse_ready,
    input logic [DUR_OUT_W-1:0] mark_duration,
    input logic [DUR_OUT_W-1:0] space_duration,
    input logic                 is_last,
    input logic [FRAME_W-1:0]   frame_word
);

    // stalled pulse holds its payload
    a_pulse_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_valid && !pulse_ready |=> pulse_valid && $stable(mark_duration)
            && $stable(space_duration) && $stable(is_last) && $stable(frame_word))
        else $error("pulse payload changed while stalled");

    // a command in flight blocks the next
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one in flight");

    // mid-frame pulses keep the block busy
    a_no_cmd_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_valid && !is_last |-> !cmd_ready)
        else $error("command port open in the middle of a frame");

    // trailer carries no space
    a_trailer_space: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_valid && is_last |-> space_duration == '0)
        else $error("trailer mark with non-zero space");

    // frame word constant within a frame
    a_frame_stable: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_valid && pulse_ready && !is_last |=> $stable(frame_word))
        else $error("frame word changed within a frame");

endmodule

bind ac_ir_frame_encoder acir_checker u_acir_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .pulse_valid    (pulse.valid),
    .pulse_ready    (pulse.ready),
    .mark_duration  (pulse.mark_duration),
    .space_duration (pulse.space_duration),
    .is_last        (pulse.is_last),
    .frame_word     (pulse.frame_word)
);

FILE: test/tb_ac_ir_frame_encoder.sv
`timescale 1ns / 100ps

module tb_ac_ir_frame_encoder;
    import acir_pkg::*;

    // Mode codes the block treats as off
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam logic [TENTHS_W-1:0] TENTHS_TOP = '1;

    // Frames that can be read straight off the format
    localparam logic [FRAME_W-1:0] FRAME_OFF      = 28'h88C0051;
    localparam logic [FRAME_W-1:0] FRAME_SWING    = 28'h8810001;
    localparam logic [FRAME_W-1:0] FRAME_COOL_ON  = 28'h8800358;  // 18 deg, auto, from off
    localparam logic [FRAME_W-1:0] FRAME_COOL_TOP = 28'h8808F4B;  // 30 deg, high, mode change

    localparam int RANDOM_PER_PHASE = 35;
    localparam int NUM_PHASES       = 6;
    localparam int DRAIN_CYCLES     = 12;

    // One command item; frame_given marks a hand-written expected frame
    typedef struct packed {
        logic                swing;
        logic [2:0]          mode;
        logic [1:0]          fan;
        logic [TENTHS_W-1:0] tenths;
        logic                frame_given;
        logic [FRAME_W-1:0]  frame;
    } cmd_row_t;

    // One pulse item as it should leave the block
    typedef struct packed {
        logic [DUR_OUT_W-1:0] mark;
        logic [DUR_OUT_W-1:0] space;
        logic                 last;
        logic [FRAME_W-1:0]   frame;
    } pulse_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    acir_cmd_if   cmd_ch ();
    acir_pulse_if pulse_ch ();

    ac_ir_frame_encoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .pulse   (pulse_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the timing and temperature registers
    logic [DUR_OUT_W-1:0] hdr_mark_us;
    logic [DUR_OUT_W-1:0] hdr_space_us;
    logic [DUR_OUT_W-1:0] bit_mark_us;
    logic [DUR_OUT_W-1:0] one_space_us;
    logic [DUR_OUT_W-1:0] zero_space_us;
    logic [DEG_W-1:0]     temp_lo_deg;
    logic [DEG_W-1:0]     temp_hi_deg;
    // Mode of the last non-swing command, drives the mode-change bit
    logic [2:0]           last_mode;

    pulse_t pulses_due[$];
    int     error_count;
    int     pulse_count;
    int     stall_left = 0;
    bit     stalls_on;
    bit     gaps_on;

    // Directed commands at reset settings. Covers every mode, both unused
    // codes, every fan speed, the rounding edge, clamping at both ends,
    // swing with junk fields and the mode-change bit across a swing.
    cmd_row_t directed_cmds [21] = '{
        '{1'b0, MODE_OFF,       FAN_SPD_AUTO, 10'd0,      1'b1, FRAME_OFF},
        '{1'b1, MODE_SPARE_7,   FAN_HIGH,     TENTHS_TOP, 1'b1, FRAME_SWING},
        '{1'b0, MODE_COOL,      FAN_SPD_AUTO, 10'd0,      1'b1, FRAME_COOL_ON},
        '{1'b0, MODE_COOL,      FAN_HIGH,     TENTHS_TOP, 1'b1, FRAME_COOL_TOP},
        '{1'b0, MODE_HEAT,      FAN_LOW,      10'd184,    1'b0, '0},
        '{1'b0, MODE_HEAT,      FAN_MED,      10'd185,    1'b0, '0},
        '{1'b1, MODE_OFF,       FAN_SPD_AUTO, 10'd0,      1'b1, FRAME_SWING},
        '{1'b0, MODE_HEAT_COOL, FAN_HIGH,     10'd250,    1'b0, '0},
        '{1'b0, MODE_DRY,       FAN_SPD_AUTO, 10'd179,    1'b0, '0},
        '{1'b0, MODE_FAN_ONLY,  FAN_MED,      10'd1000,   1'b0, '0},
        '{1'b0, MODE_OFF,       FAN_HIGH,     TENTHS_TOP, 1'b1, FRAME_OFF},
        '{1'b0, MODE_FAN_ONLY,  FAN_LOW,      10'd0,      1'b0, '0},
        '{1'b0, MODE_SPARE_6,   FAN_MED,      10'd512,    1'b1, FRAME_OFF},
        '{1'b0, MODE_DRY,       FAN_HIGH,     10'd301,    1'b0, '0},
        '{1'b0, MODE_SPARE_7,   FAN_LOW,      10'd341,    1'b1, FRAME_OFF},
        '{1'b0, MODE_HEAT_COOL, FAN_SPD_AUTO, 10'd0,      1'b0, '0},
        '{1'b0, MODE_COOL,      FAN_LOW,      10'd295,    1'b0, '0},
        '{1'b0, MODE_HEAT,      FAN_HIGH,     10'd1000,   1'b0, '0},
        '{1'b0, MODE_COOL,      FAN_MED,      10'd180,    1'b0, '0},
        '{1'b1, MODE_FAN_ONLY,  FAN_MED,      10'd682,    1'b1, FRAME_SWING},
        '{1'b0, MODE_DRY,       FAN_LOW,      10'd682,    1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, several times the slowest legal run
    initial
    begin
        #10_000_000;
        $display("tb_ac_ir_frame_encoder failed");
        $finish;
    end

    // Mostly short idles, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    // Room for a stray burst after the last pulse due
    function automatic int FRAME_BITS_GUARD();
        return FRAME_W + 12;
    endfunction

    // Frame for one command; updates the remembered mode as the block does
    function automatic logic [FRAME_W-1:0] compose_frame(logic swing, logic [2:0] mode,
                                                         logic [1:0] fan,
                                                         logic [TENTHS_W-1:0] tenths);
        logic [FRAME_W-1:0] w;
        logic [2:0]         m;
        logic [3:0]         sum;
        int unsigned        t;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        deg;
        w = SIGNATURE;
        if (swing)
            w |= CMD_SWING;
        else
        begin
            m = (mode > MODE_FAN_ONLY) ? MODE_OFF : mode;
            case (m)
                MODE_HEAT:      w |= CMD_HEAT;
                MODE_HEAT_COOL: w |= CMD_HEAT_COOL;
                MODE_DRY:       w |= CMD_DRY;
                MODE_FAN_ONLY:  w |= CMD_FAN_ONLY;
                MODE_COOL:      ;
                default:        w |= CMD_OFF;
            endcase
            // no change flag when switching on from off, nor when switching off
            if (m != MODE_OFF && last_mode != MODE_OFF)
                w |= CMD_MODE_CHANGE;
            last_mode = m;
            if (m == MODE_OFF)
                w |= FRAME_W'(FAN_NIB_AUTO);
            else if (m != MODE_HEAT_COOL)
            begin
                case (fan)
                    FAN_HIGH: w |= FRAME_W'(FAN_NIB_HIGH);
                    FAN_MED:  w |= FRAME_W'(FAN_NIB_MED);
                    FAN_LOW:  ;
                    default:  w |= FRAME_W'(FAN_NIB_AUTO);
                endcase
            end
            if (m == MODE_COOL || m == MODE_HEAT || m == MODE_DRY)
            begin
                // lower bound first, so a crossed upper bound wins
                lo  = temp_lo_deg * 10;
                hi  = temp_hi_deg * 10;
                t   = tenths;
                if (t < lo)
                    t = lo;
                if (t > hi)
                    t = hi;
                deg = (t + 5) / 10;
                if (deg < DEG_MIN)
                    deg = DEG_MIN;
                if (deg > DEG_MAX)
                    deg = DEG_MAX;
                w |= FRAME_W'(deg - DEG_MIN) << 8;
            end
            if (m == MODE_FAN_ONLY)
                w |= FRAME_W'(FAN_ONLY_NIB) << 8;
        end
        sum = '0;
        for (int i = 1; i < FRAME_W / 4; i++)
            sum += w[4*i +: 4];
        return w | FRAME_W'(sum);
    endfunction

    // Header, one pulse per bit MSB first, then the trailer mark
    function automatic void queue_burst(logic [FRAME_W-1:0] f);
        pulses_due.push_back('{hdr_mark_us, hdr_space_us, 1'b0, f});
        for (int b = FRAME_W - 1; b >= 0; b--)
            pulses_due.push_back('{bit_mark_us, f[b] ? one_space_us : zero_space_us, 1'b0, f});
        pulses_due.push_back('{bit_mark_us, {DUR_OUT_W{1'b0}}, 1'b1, f});
    endfunction

    function automatic void flag_error(string what, logic [31:0] want, logic [31:0] got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at pulse %0d, %s: want %h got %h", pulse_count, what, want, got);
    endfunction

    // Random command with most of the weight on real modes
    function automatic cmd_row_t random_cmd();
        cmd_row_t    row;
        int unsigned pick;
        row       = '0;
        row.swing = ($urandom_range(0, 7) == 0);
        pick      = $urandom_range(0, 15);
        row.mode  = (pick < 14) ? 3'(pick % 6) : ((pick == 14) ? MODE_SPARE_6 : MODE_SPARE_7);
        row.fan   = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0:       row.tenths = '0;
            1:       row.tenths = TENTHS_TOP;
            2, 3:    row.tenths = TENTHS_W'(10 * $urandom_range(14, 31) + $urandom_range(0, 9));
            default: row.tenths = TENTHS_W'($urandom_range(0, 1023));
        endcase
        return row;
    endfunction

    task automatic send_cmd(input cmd_row_t row);
        logic [FRAME_W-1:0] f;
        cmd_ch.valid         <= 1'b1;
        cmd_ch.swing_toggle  <= row.swing;
        cmd_ch.mode_code     <= row.mode;
        cmd_ch.fan_code      <= row.fan;
        cmd_ch.target_tenths <= row.tenths;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        // accepted at this edge; the predictor runs even for typed rows
        // so that the remembered mode stays in step
        f = compose_frame(row.swing, row.mode, row.fan, row.tenths);
        queue_burst(row.frame_given ? row.frame : f);
        // valid stays high for a back-to-back item, else drops for the gap
        if (gaps_on && $urandom_range(0, 1) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
    endtask

    // Sender holds off until every pulse is out, then the block is idle
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pulses_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all seven registers back to back over APB
    task automatic program_regs(input logic [31:0] vals [7]);
        logic [2:0] idx;
        for (int i = 0; i < 7; i++)
        begin
            idx     = 3'(i);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= vals[i];
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            case (idx)
                REG_HEADER_MARK:  hdr_mark_us   = vals[i][DUR_OUT_W-1:0];
                REG_HEADER_SPACE: hdr_space_us  = vals[i][DUR_OUT_W-1:0];
                REG_BIT_MARK:     bit_mark_us   = vals[i][DUR_OUT_W-1:0];
                REG_ONE_SPACE:    one_space_us  = vals[i][DUR_OUT_W-1:0];
                REG_ZERO_SPACE:   zero_space_us = vals[i][DUR_OUT_W-1:0];
                REG_TEMP_MIN:     temp_lo_deg   = vals[i][DEG_W-1:0];
                REG_TEMP_MAX:     temp_hi_deg   = vals[i][DEG_W-1:0];
                default:          ;
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stalls while enabled, solid ready otherwise
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left     <= stall_left - 1;
            pulse_ch.ready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            stall_left     <= idle_len() - 1;
            pulse_ch.ready <= 1'b0;
        end
        else
            pulse_ch.ready <= 1'b1;
    end

    // Every pulse taken is checked against the oldest one due
    always @(posedge clk)
    begin : check_pulses
        pulse_t want;
        if (rst_n && pulse_ch.valid && pulse_ch.ready)
        begin
            if (pulses_due.size() == 0)
                flag_error("pulse with none due, frame", '0, 32'(pulse_ch.frame_word));
            else
            begin
                want = pulses_due.pop_front();
                if (want.mark !== pulse_ch.mark_duration)
                    flag_error("mark_duration", 32'(want.mark), 32'(pulse_ch.mark_duration));
                if (want.space !== pulse_ch.space_duration)
                    flag_error("space_duration", 32'(want.space),
                               32'(pulse_ch.space_duration));
                if (want.last !== pulse_ch.is_last)
                    flag_error("is_last", 32'(want.last), 32'(pulse_ch.is_last));
                if (want.frame !== pulse_ch.frame_word)
                    flag_error("frame_word", 32'(want.frame), 32'(pulse_ch.frame_word));
            end
            pulse_count++;
        end
    end

    initial
    begin : stimulus
        logic [31:0] regs [7];
        cmd_ch.valid         <= 1'b0;
        cmd_ch.swing_toggle  <= 1'b0;
        cmd_ch.mode_code     <= MODE_OFF;
        cmd_ch.fan_code      <= FAN_SPD_AUTO;
        cmd_ch.target_tenths <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        rst_n                <= 1'b0;
        stalls_on            = 1'b0;
        gaps_on              = 1'b0;
        error_count          = 0;
        pulse_count          = 0;

        hdr_mark_us   = HDR_MARK_RST;
        hdr_space_us  = HDR_SPACE_RST;
        bit_mark_us   = BIT_MARK_RST;
        one_space_us  = ONE_SPACE_RST;
        zero_space_us = ZERO_SPACE_RST;
        temp_lo_deg   = TEMP_MIN_RST;
        temp_hi_deg   = TEMP_MAX_RST;
        last_mode     = MODE_OFF;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings, both sides idling
        stalls_on = 1'b1;
        gaps_on   = 1'b1;
        foreach (directed_cmds[i])
            send_cmd(directed_cmds[i]);

        // Random part, a fresh register set per phase
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            case (p)
                // top and zero durations, upper halves of pwdata must be dropped
                0: regs = '{32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_FFFF, 32'h1234_FFFF,
                            32'hFFFF_0000, 32'hFFFF_FFEF, 32'h0000_001E};
                // zero durations; crossed bounds, upper one wins
                1: regs = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                            32'h0000_0000, 32'h0000_001E, 32'h0000_000F};
                // bounds outside 15..30, degrees saturate into the nibble
                2: regs = '{32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004,
                            32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFFF};
                // back to the reset timings
                5: regs = '{32'(HDR_MARK_RST), 32'(HDR_SPACE_RST), 32'(BIT_MARK_RST),
                            32'(ONE_SPACE_RST), 32'(ZERO_SPACE_RST), 32'(TEMP_MIN_RST),
                            32'(TEMP_MAX_RST)};
                default:
                begin
                    foreach (regs[i])
                        regs[i] = $urandom;
                end
            endcase
            program_regs(regs);
            // one phase runs flat out: no gaps, no stalls
            stalls_on = (p != 4);
            gaps_on   = (p != 4);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_cmd(random_cmd());
        end

        drain();
        repeat (FRAME_BITS_GUARD()) @(posedge clk);
        if (error_count == 0 && pulses_due.size() == 0)
            $display("tb_ac_ir_frame_encoder passed");
        else
            $display("tb_ac_ir_frame_encoder failed");
        $finish;
    end

endmodule
